### sv/mvr_pkg.sv
// mvr_pkg: shared types, constants and the arctangent table of the mouse view rotator
// used by mvr_ctrl, mvr_datapath and mouse_view_rotator_top; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mvr_pkg;

    // field widths
    localparam int POS_W      = 13;
    localparam int DELTA_W    = 14;
    localparam int SENS_W     = 16;
    localparam int WIN_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_DIR_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_DIR_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_PLANE_X = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START_PLANE_Y = 3'd6;

    // reset values
    localparam logic [SENS_W-1:0] SENS_RESET   = 16'd2097;
    localparam logic [WIN_W-1:0]  WIDTH_RESET  = 12'd1024;
    localparam logic [WIN_W-1:0]  HEIGHT_RESET = 12'd768;
    localparam int START_DIR_X   = -65536;
    localparam int START_DIR_Y   = 0;
    localparam int START_PLANE_X = 0;
    localparam int START_PLANE_Y = 43254;

    // angles in units of 2^-30 rad
    localparam int ANG_W      = 34;
    localparam int REM_W      = 41;
    localparam int ANG_SCALE  = 10;
    localparam int PROD_MAG_W = 30;
    localparam logic [32:0] ANG_HALF_PI = 33'd1686629713;
    localparam logic [32:0] ANG_PI      = 33'd3373259426;
    localparam logic [32:0] ANG_TWO_PI  = 33'd6746518852;
    localparam logic [32:0] ANG_FOLD_HI = 33'd5059889139;

    // cordic and gain compensation
    localparam int GUARD    = 12;
    localparam int GAIN_W   = 30;
    localparam int LO_W     = 16;
    localparam int ATAN_W   = 30;
    localparam int ATAN_LEN = 30;
    localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032875;

    // sequencer steps
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] REDUCE_TOP     = 5'd7;
    localparam logic [STEP_W-1:0] GAIN_MUL_STEPS = 5'd8;
    localparam logic [STEP_W-1:0] GAIN_LAST      = 5'd9;
    localparam logic [STEP_W-1:0] GAIN_SAT_FIRST = 5'd3;

    typedef struct packed {
        logic              capture;
        logic              mul_angle;
        logic              load_rem;
        logic              reduce;
        logic              wrap;
        logic              fold;
        logic              cordic;
        logic              gain;
        logic              publish;
        logic [STEP_W-1:0] step;
    } mvr_cmd_t;

    typedef struct packed {
        logic in_window;
        logic ang_zero;
    } mvr_status_t;

    function automatic logic [ATAN_W-1:0] atan_val(input logic [STEP_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 30'd843314857;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043837;
            5'd3:    v = 30'd133525159;
            5'd4:    v = 30'd67021687;
            5'd5:    v = 30'd33543516;
            5'd6:    v = 30'd16775851;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194283;
            5'd9:    v = 30'd2097149;
            5'd10:   v = 30'd1048576;
            5'd11:   v = 30'd524288;
            5'd12:   v = 30'd262144;
            5'd13:   v = 30'd131072;
            5'd14:   v = 30'd65536;
            5'd15:   v = 30'd32768;
            5'd16:   v = 30'd16384;
            5'd17:   v = 30'd8192;
            5'd18:   v = 30'd4096;
            5'd19:   v = 30'd2048;
            5'd20:   v = 30'd1024;
            5'd21:   v = 30'd512;
            5'd22:   v = 30'd256;
            5'd23:   v = 30'd128;
            5'd24:   v = 30'd64;
            5'd25:   v = 30'd32;
            5'd26:   v = 30'd16;
            5'd27:   v = 30'd8;
            5'd28:   v = 30'd4;
            5'd29:   v = 30'd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### sv/mvr_ctrl.sv
// mvr_ctrl: state machine that sequences one mouse event through the datapath
// depends on mvr_pkg (command and status structs, step constants)
`timescale 1ns / 1ps
`default_nettype none

module mvr_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire                  out_ready,
    input  mvr_pkg::mvr_status_t status,
    output mvr_pkg::mvr_cmd_t    cmd
);

    localparam int NSTEPS = (CORDIC_STEPS > mvr_pkg::ATAN_LEN) ? mvr_pkg::ATAN_LEN
                                                                : CORDIC_STEPS;
    localparam logic [mvr_pkg::STEP_W-1:0] CORDIC_LAST = mvr_pkg::STEP_W'(NSTEPS - 1);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_MUL    = 9'b000000010,
        S_LOAD   = 9'b000000100,
        S_REDUCE = 9'b000001000,
        S_WRAP   = 9'b000010000,
        S_FOLD   = 9'b000100000,
        S_CORDIC = 9'b001000000,
        S_GAIN   = 9'b010000000,
        S_DONE   = 9'b100000000
    } mvr_state_t;

    mvr_state_t                   state_reg, state_next;
    logic [mvr_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                         out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.step   = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = status.in_window ? S_MUL : S_DONE;
                end
            end
            S_MUL:
            begin
                cmd.mul_angle = 1'b1;
                state_next    = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load_rem = 1'b1;
                step_next    = mvr_pkg::REDUCE_TOP;
                state_next   = S_REDUCE;
            end
            S_REDUCE:
            begin
                cmd.reduce = 1'b1;
                if (step_reg == '0)
                begin
                    state_next = S_WRAP;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            S_WRAP:
            begin
                cmd.wrap   = 1'b1;
                state_next = S_FOLD;
            end
            S_FOLD:
            begin
                cmd.fold   = 1'b1;
                step_next  = '0;
                state_next = status.ang_zero ? S_DONE : S_CORDIC;
            end
            S_CORDIC:
            begin
                cmd.cordic = 1'b1;
                if (step_reg == CORDIC_LAST)
                begin
                    step_next  = '0;
                    state_next = S_GAIN;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_GAIN:
            begin
                cmd.gain = 1'b1;
                if (step_reg == mvr_pkg::GAIN_LAST)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

### sv/mvr_datapath.sv
// mvr_datapath: config registers, view state, angle multiply and reduction,
// two cordic lanes and the shared gain multiplier; depends on mvr_pkg
`timescale 1ns / 1ps
`default_nettype none

module mvr_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire signed [mvr_pkg::POS_W-1:0]       pos_x,
    input  wire signed [mvr_pkg::POS_W-1:0]       pos_y,
    input  wire                                   cfg_we,
    input  wire        [mvr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire        [mvr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  mvr_pkg::mvr_cmd_t                     cmd,
    output mvr_pkg::mvr_status_t                  status,
    output logic signed [FRAC_BITS+1:0]           out_dir_x,
    output logic signed [FRAC_BITS+1:0]           out_dir_y,
    output logic signed [FRAC_BITS+1:0]           out_plane_x,
    output logic signed [FRAC_BITS+1:0]           out_plane_y,
    output logic                                  rotated
);

    localparam int VEC_W   = FRAC_BITS + 2;
    localparam int W       = VEC_W + mvr_pkg::GUARD + 3;
    localparam int MUL_A_W = (W - mvr_pkg::LO_W > 17) ? W - mvr_pkg::LO_W : 17;
    localparam int P_W     = MUL_A_W + mvr_pkg::GAIN_W + 1;
    localparam int ACC_W   = W + mvr_pkg::GAIN_W + 1;
    localparam int SHIFT   = mvr_pkg::GAIN_W + mvr_pkg::GUARD;
    localparam int Q_W     = ACC_W - SHIFT;
    localparam int ANG_W   = mvr_pkg::ANG_W;
    localparam int REM_W   = mvr_pkg::REM_W;
    localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(1) << (SHIFT - 1);

    // configuration and view state
    logic        [mvr_pkg::SENS_W-1:0] sens_reg;
    logic        [mvr_pkg::WIN_W-1:0]  width_reg;
    logic        [mvr_pkg::WIN_W-1:0]  height_reg;
    logic signed [mvr_pkg::POS_W-1:0]  last_x_reg;
    logic signed [VEC_W-1:0]           view_reg [4];

    // working registers
    logic signed [mvr_pkg::DELTA_W-1:0] delta_reg;
    logic                               inside_reg;
    logic signed [P_W-1:0]              mul_reg;
    logic        [REM_W-1:0]            rem_reg;
    logic                               neg_reg;
    logic signed [ANG_W-1:0]            z_reg;
    logic signed [W-1:0]                v_reg [4];
    logic signed [ACC_W-1:0]            acc_reg;
    logic signed [VEC_W-1:0]            out_reg [4];
    logic                               rotated_reg;

    logic                               in_window;
    logic signed [MUL_A_W-1:0]          mul_a;
    logic signed [mvr_pkg::GAIN_W:0]    mul_b;
    logic                               mul_en;
    logic signed [W-1:0]                gain_src;
    logic signed [P_W-1:0]              prod_mag;
    logic        [REM_W-1:0]            reduce_sub;
    logic        [32:0]                 r;
    logic        [32:0]                 fold_sub;
    logic                               fold_flip;
    logic signed [ANG_W-1:0]            fold_z;
    logic signed [ANG_W-1:0]            atan_z;
    logic                               z_pos;
    logic signed [W-1:0]                v_next [4];
    logic signed [W-1:0]                v_load [4];
    logic        [mvr_pkg::STEP_W-1:0]  k;
    logic        [mvr_pkg::STEP_W-1:0]  k_sat;
    logic        [1:0]                  sat_idx;
    logic                               acc_en;
    logic                               sat_en;
    logic signed [ACC_W-1:0]            mul_ext;
    logic signed [Q_W-1:0]              q;
    logic signed [VEC_W-1:0]            sat_val;

    // window test
    always_comb
    begin
        in_window = !pos_x[mvr_pkg::POS_W-1] && !pos_y[mvr_pkg::POS_W-1]
                    && (pos_x[mvr_pkg::WIN_W-1:0] < width_reg)
                    && (pos_y[mvr_pkg::WIN_W-1:0] < height_reg);
    end

    assign status.in_window = in_window;
    assign status.ang_zero  = (rem_reg == '0);

    // shared multiplier operands
    assign k        = cmd.step;
    assign gain_src = v_reg[k[2:1]];

    always_comb
    begin
        if (cmd.mul_angle)
        begin
            mul_a = MUL_A_W'(delta_reg);
            mul_b = (mvr_pkg::GAIN_W + 1)'(sens_reg);
        end
        else
        begin
            if (k[0])
            begin
                mul_a = MUL_A_W'(gain_src[mvr_pkg::LO_W-1:0]);
            end
            else
            begin
                mul_a = MUL_A_W'(signed'(gain_src[W-1:mvr_pkg::LO_W]));
            end
            mul_b = (mvr_pkg::GAIN_W + 1)'(mvr_pkg::GAIN_Q30);
        end
        mul_en = cmd.mul_angle || (cmd.gain && (k < mvr_pkg::GAIN_MUL_STEPS));
    end

    // angle reduction
    always_comb
    begin
        prod_mag   = mul_reg[P_W-1] ? -mul_reg : mul_reg;
        reduce_sub = REM_W'(mvr_pkg::ANG_TWO_PI) << k[2:0];
        r          = rem_reg[32:0];
        if (r <= mvr_pkg::ANG_HALF_PI)
        begin
            fold_sub  = '0;
            fold_flip = 1'b0;
        end
        else if (r < mvr_pkg::ANG_FOLD_HI)
        begin
            fold_sub  = mvr_pkg::ANG_PI;
            fold_flip = 1'b1;
        end
        else
        begin
            fold_sub  = mvr_pkg::ANG_TWO_PI;
            fold_flip = 1'b0;
        end
        fold_z = signed'(ANG_W'(r) - ANG_W'(fold_sub));
    end

    // cordic lanes: dir in entries 0 and 1, plane in entries 2 and 3
    always_comb
    begin
        atan_z = ANG_W'(mvr_pkg::atan_val(k));
        z_pos  = !z_reg[ANG_W-1];
        for (int l = 0; l < 2; l++)
        begin
            if (z_pos)
            begin
                v_next[2*l]   = v_reg[2*l]   - (v_reg[2*l+1] >>> k);
                v_next[2*l+1] = v_reg[2*l+1] + (v_reg[2*l]   >>> k);
            end
            else
            begin
                v_next[2*l]   = v_reg[2*l]   + (v_reg[2*l+1] >>> k);
                v_next[2*l+1] = v_reg[2*l+1] - (v_reg[2*l]   >>> k);
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            v_load[c] = W'(view_reg[c]) <<< mvr_pkg::GUARD;
            if (fold_flip)
            begin
                v_load[c] = -v_load[c];
            end
        end
    end

    // gain compensation: high half then low half per component, then saturate into the view state
    always_comb
    begin
        k_sat   = k - mvr_pkg::GAIN_SAT_FIRST;
        sat_idx = k_sat[2:1];
        acc_en  = cmd.gain && (k != '0) && (k <= mvr_pkg::GAIN_MUL_STEPS);
        sat_en  = cmd.gain && k[0] && (k >= mvr_pkg::GAIN_SAT_FIRST);
        mul_ext = ACC_W'(mul_reg);
        q       = acc_reg[ACC_W-1:SHIFT];
        if ((&q[Q_W-1:VEC_W-1]) || !(|q[Q_W-1:VEC_W-1]))
        begin
            sat_val = q[VEC_W-1:0];
        end
        else if (q[Q_W-1])
        begin
            sat_val = {1'b1, {(VEC_W-1){1'b0}}};
        end
        else
        begin
            sat_val = {1'b0, {(VEC_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_reg    <= mvr_pkg::SENS_RESET;
            width_reg   <= mvr_pkg::WIDTH_RESET;
            height_reg  <= mvr_pkg::HEIGHT_RESET;
            last_x_reg  <= '0;
            view_reg[0] <= VEC_W'(mvr_pkg::START_DIR_X);
            view_reg[1] <= VEC_W'(mvr_pkg::START_DIR_Y);
            view_reg[2] <= VEC_W'(mvr_pkg::START_PLANE_X);
            view_reg[3] <= VEC_W'(mvr_pkg::START_PLANE_Y);
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    mvr_pkg::REG_SENSITIVITY:   sens_reg    <= cfg_data[mvr_pkg::SENS_W-1:0];
                    mvr_pkg::REG_WINDOW_WIDTH:  width_reg   <= cfg_data[mvr_pkg::WIN_W-1:0];
                    mvr_pkg::REG_WINDOW_HEIGHT: height_reg  <= cfg_data[mvr_pkg::WIN_W-1:0];
                    mvr_pkg::REG_START_DIR_X:   view_reg[0] <= cfg_data[VEC_W-1:0];
                    mvr_pkg::REG_START_DIR_Y:   view_reg[1] <= cfg_data[VEC_W-1:0];
                    mvr_pkg::REG_START_PLANE_X: view_reg[2] <= cfg_data[VEC_W-1:0];
                    mvr_pkg::REG_START_PLANE_Y: view_reg[3] <= cfg_data[VEC_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.capture)
            begin
                last_x_reg <= pos_x;
            end
            if (sat_en)
            begin
                view_reg[sat_idx] <= sat_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            delta_reg  <= mvr_pkg::DELTA_W'(pos_x) - mvr_pkg::DELTA_W'(last_x_reg);
            inside_reg <= in_window;
        end
        if (mul_en)
        begin
            mul_reg <= mul_a * mul_b;
        end
        if (cmd.load_rem)
        begin
            rem_reg <= REM_W'(prod_mag[mvr_pkg::PROD_MAG_W-1:0]) << mvr_pkg::ANG_SCALE;
            neg_reg <= !mul_reg[P_W-1] && (mul_reg != '0);
        end
        if (cmd.reduce && (rem_reg >= reduce_sub))
        begin
            rem_reg <= rem_reg - reduce_sub;
        end
        if (cmd.wrap && neg_reg && (rem_reg != '0))
        begin
            rem_reg <= REM_W'(mvr_pkg::ANG_TWO_PI) - rem_reg;
        end
        if (cmd.fold)
        begin
            z_reg <= fold_z;
            for (int c = 0; c < 4; c++)
            begin
                v_reg[c] <= v_load[c];
            end
        end
        if (cmd.cordic)
        begin
            z_reg <= z_pos ? z_reg - atan_z : z_reg + atan_z;
            for (int c = 0; c < 4; c++)
            begin
                v_reg[c] <= v_next[c];
            end
        end
        if (acc_en)
        begin
            if (k[0])
            begin
                acc_reg <= (mul_ext <<< mvr_pkg::LO_W) + ROUND;
            end
            else
            begin
                acc_reg <= acc_reg + mul_ext;
            end
        end
        if (cmd.publish)
        begin
            for (int c = 0; c < 4; c++)
            begin
                out_reg[c] <= view_reg[c];
            end
            rotated_reg <= inside_reg;
        end
    end

    assign out_dir_x   = out_reg[0];
    assign out_dir_y   = out_reg[1];
    assign out_plane_x = out_reg[2];
    assign out_plane_y = out_reg[3];
    assign rotated     = rotated_reg;

endmodule

`default_nettype wire

### sv/mouse_view_rotator_top.sv
// mouse_view_rotator_top: turns the camera direction and plane vectors on mouse events
// instantiates mvr_ctrl and mvr_datapath; depends on mvr_pkg
//
// usage
//   input channel (in_valid/in_ready, pos_x, pos_y): one mouse event per transfer
//   output channel (out_valid/out_ready): one result per event, four Q2.FRAC_BITS
//     vector components plus the rotated flag
//   config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready, write
//     only while no event is in flight; a start vector write also loads the view state
// timing
//   event outside the window: the sequencer goes straight to publishing the result
//   event inside the window: an 8 step modulo 2*pi reduction, min(CORDIC_STEPS, 30)
//     cordic iterations at one per cycle and a 10 step gain compensation on one shared
//     multiplier
//   a zero angle skips the rotation; in_ready rises in the cycle after publish
//   a finished result waits in the output register; the next event is accepted
//     meanwhile and holds at its end until the output register is free
// reset
//   clears the sequencer and output valid, restores the config defaults, the start
//   vectors and last x of zero
`timescale 1ns / 1ps
`default_nettype none

module mouse_view_rotator_top #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   in_valid,
    output logic                                  in_ready,
    input  wire signed [mvr_pkg::POS_W-1:0]       pos_x,
    input  wire signed [mvr_pkg::POS_W-1:0]       pos_y,
    output logic                                  out_valid,
    input  wire                                   out_ready,
    output logic signed [FRAC_BITS+1:0]           out_dir_x,
    output logic signed [FRAC_BITS+1:0]           out_dir_y,
    output logic signed [FRAC_BITS+1:0]           out_plane_x,
    output logic signed [FRAC_BITS+1:0]           out_plane_y,
    output logic                                  rotated,
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire        [mvr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire        [mvr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    mvr_pkg::mvr_cmd_t    cmd;
    mvr_pkg::mvr_status_t status;

    assign cfg_ready = 1'b1;

    mvr_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    mvr_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .status      (status),
        .out_dir_x   (out_dir_x),
        .out_dir_y   (out_dir_y),
        .out_plane_x (out_plane_x),
        .out_plane_y (out_plane_y),
        .rotated     (rotated)
    );

    // an accepted event keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready
    ) else $error("input accepted again right after a transfer");

    // a new result appears only at the end of an event in flight
    a_result_from_event: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready)
    ) else $error("result published with no event in flight");

    // an event outside the window never runs the rotation path
    a_outside_short: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !status.in_window) |=> !cmd.mul_angle
    ) else $error("rotation started for a point outside the window");

endmodule

`default_nettype wire
